FILE: hw/rtl/rbm_pkg.sv
// ----------------------------------------------------------------------------
// rbm_pkg
// shared constants and types for the reachability bit matrix
// ----------------------------------------------------------------------------
package rbm_pkg;

  localparam int ROWS    = 64;
  localparam int ROW_AW  = $clog2(ROWS);
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int OP_W    = 2;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_START = 2'd1,
    ACT_ADD   = 2'd2,
    ACT_QUERY = 2'd3
  } action_t;

  typedef struct packed {
    action_t            action;
    logic               err;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   other;
    logic               keep;
  } entry_t;

endpackage

FILE: hw/rtl/rbm_front.sv
// ----------------------------------------------------------------------------
// rbm_front
// accepts input beats, holds op_count, checks indices and classifies items
// ----------------------------------------------------------------------------
module rbm_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // op[1:0], row_index[7:2], other_index[13:8], keep_row[14], zero[15]
  input  logic [rbm_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rbm_pkg::CNT_W-1:0]           cfg_data,
  input  logic                                q_full,
  output logic                                push,
  output rbm_pkg::entry_t                     entry
);

  logic [rbm_pkg::CNT_W-1:0] op_count;
  logic [rbm_pkg::OP_W-1:0]  op;
  logic [rbm_pkg::IDX_W-1:0] row_index;
  logic [rbm_pkg::IDX_W-1:0] other_index;
  logic                      keep_row;
  logic                      row_ok;
  logic                      other_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_count <= '0;
    end else if (cfg_valid) begin
      op_count <= cfg_data;
    end
  end

  assign op          = s_tdata[1:0];
  assign row_index   = s_tdata[7:2];
  assign other_index = s_tdata[13:8];
  assign keep_row    = s_tdata[14];

  assign row_ok   = (rbm_pkg::CNT_W'(row_index) < op_count) &&
                    (rbm_pkg::CNT_W'(row_index) < rbm_pkg::CNT_W'(rbm_pkg::ROWS));
  assign other_ok = (rbm_pkg::CNT_W'(other_index) < op_count) &&
                    (rbm_pkg::CNT_W'(other_index) < rbm_pkg::CNT_W'(rbm_pkg::ROWS));

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    entry.row    = row_index;
    entry.other  = other_index;
    entry.keep   = keep_row;
    entry.err    = 1'b0;
    entry.action = rbm_pkg::ACT_NONE;
    case (op)
      rbm_pkg::OP_START: begin
        if (!row_ok) begin
          entry.err = 1'b1;
        end else begin
          entry.action = rbm_pkg::ACT_START;
        end
      end
      rbm_pkg::OP_ADD: begin
        if (!row_ok || !other_ok) begin
          entry.err = 1'b1;
        end else if (row_index != other_index) begin
          entry.action = rbm_pkg::ACT_ADD;
        end
      end
      rbm_pkg::OP_QUERY: begin
        if (!row_ok || !other_ok) begin
          entry.err = 1'b1;
        end else begin
          entry.action = rbm_pkg::ACT_QUERY;
        end
      end
      default: begin
        entry.action = rbm_pkg::ACT_NONE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/rbm_queue.sv
// ----------------------------------------------------------------------------
// rbm_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module rbm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rbm_pkg::entry_t push_entry,
  input  logic            pop,
  output rbm_pkg::entry_t head,
  output logic            empty,
  output logic            full
);

  rbm_pkg::entry_t                 slots [rbm_pkg::QDEPTH];
  logic [rbm_pkg::QPTR_W-1:0]      wr_ptr;
  logic [rbm_pkg::QPTR_W-1:0]      rd_ptr;
  logic [rbm_pkg::QCNT_W-1:0]      count;

  assign empty = (count == '0);
  assign full  = (count == rbm_pkg::QCNT_W'(rbm_pkg::QDEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/rbm_back.sv
// ----------------------------------------------------------------------------
// rbm_back
// reads rows from the matrix memory, updates them and registers the result
// ----------------------------------------------------------------------------
module rbm_back (
  input  logic                              clk,
  input  logic                              rst,
  input  rbm_pkg::entry_t                   head,
  input  logic                              empty,
  output logic                              pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // connected[0], index_error[1], zero[7:2]
  output logic [rbm_pkg::OUT_DATA_W-1:0]    m_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t                      state;
  state_t                      state_next;
  rbm_pkg::entry_t             cur;
  logic [rbm_pkg::ROWS-1:0]    mem [rbm_pkg::ROWS];
  logic [rbm_pkg::ROWS-1:0]    row_valid;
  logic [rbm_pkg::ROWS-1:0]    rd_a;
  logic [rbm_pkg::ROWS-1:0]    rd_b;
  logic                        rd_a_ok;
  logic                        rd_b_ok;
  logic [rbm_pkg::ROWS-1:0]    row_a;
  logic [rbm_pkg::ROWS-1:0]    row_b;
  logic [rbm_pkg::ROWS-1:0]    wr_data;
  logic                        wr_en;
  logic                        finish;
  logic                        connected;
  logic                        index_error;
  logic [rbm_pkg::ROW_AW-1:0]  cur_row;
  logic [rbm_pkg::ROW_AW-1:0]  cur_other;

  assign pop    = (state == ST_IDLE) && !empty;
  assign finish = (state == ST_EXEC) && (!m_tvalid || m_tready);

  assign cur_row   = cur.row[rbm_pkg::ROW_AW-1:0];
  assign cur_other = cur.other[rbm_pkg::ROW_AW-1:0];
  assign row_a     = rd_a_ok ? rd_a : '0;
  assign row_b     = rd_b_ok ? rd_b : '0;

  always_comb begin
    wr_en   = 1'b0;
    wr_data = row_b;
    case (cur.action)
      rbm_pkg::ACT_START: begin
        wr_en   = finish;
        wr_data = (cur.keep ? row_b : '0) |
                  (rbm_pkg::ROWS'(1) << cur_row);
      end
      rbm_pkg::ACT_ADD: begin
        wr_en   = finish;
        wr_data = row_b | row_a;
      end
      default: begin
        wr_en   = 1'b0;
      end
    endcase
  end

  assign connected   = (cur.action == rbm_pkg::ACT_QUERY) ? row_b[cur_other] : 1'b0;
  assign index_error = cur.err;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (pop) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // row memory: two registered reads, one write
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_a <= mem[head.other[rbm_pkg::ROW_AW-1:0]];
      rd_b <= mem[head.row[rbm_pkg::ROW_AW-1:0]];
      cur  <= head;
    end
    if (wr_en) begin
      mem[cur_row] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_valid <= '0;
      rd_a_ok   <= 1'b0;
      rd_b_ok   <= 1'b0;
      m_tvalid  <= 1'b0;
      m_tdata   <= '0;
    end else begin
      state <= state_next;
      if (pop) begin
        rd_a_ok <= row_valid[head.other[rbm_pkg::ROW_AW-1:0]];
        rd_b_ok <= row_valid[head.row[rbm_pkg::ROW_AW-1:0]];
      end
      if (wr_en) begin
        row_valid[cur_row] <= 1'b1;
      end
      if (finish) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {{(rbm_pkg::OUT_DATA_W-2){1'b0}}, index_error, connected};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/reachability_bit_matrix.sv
// ----------------------------------------------------------------------------
// reachability_bit_matrix
// Keeps one 64-bit reach row per operation index and answers reach queries.
// Input beats on s_* carry start-row, add-producer and query items; every
// beat gives exactly one result beat on m_* (connected, index_error).
// op_count is written on the cfg channel, which is always ready; write it
// only while no item is in flight.
// An accepted beat enters a two-entry queue; the back end pops it, reads the
// target and producer rows from the row memory (registered read), then
// writes the updated row and loads the result register. Items go through the
// read-then-write sequence on the single row memory one at a time: the back
// end pops a new item only after the last one has loaded its result.
// If m_tready is low the result register holds; the queue keeps taking
// beats until it is full, then s_tready drops.
// Reset clears op_count, the queue and all row valid flags at once, so the
// whole matrix reads as zero from the first cycle after reset.
// ----------------------------------------------------------------------------
module reachability_bit_matrix (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // op[1:0], row_index[7:2], other_index[13:8], keep_row[14], zero[15]
  input  logic [rbm_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // connected[0], index_error[1], zero[7:2]
  output logic [rbm_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rbm_pkg::CNT_W-1:0]         cfg_data
);

  rbm_pkg::entry_t push_entry;
  rbm_pkg::entry_t head;
  logic            push;
  logic            pop;
  logic            q_empty;
  logic            q_full;

  rbm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .entry     (push_entry)
  );

  rbm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  rbm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
